// File: src/pwrwe_pkg.sv
// Package for the select-line register write encoder.
// Holds payload widths, register defaults, beat structs and shared codes.
// No dependencies.
`default_nettype none

package pwrwe_pkg;

    // Frame and field widths.
    localparam int FRAME_W      = 24;
    localparam int FRAME_BITS_D = 24;
    localparam int DEV_W        = 7;
    localparam int BYTE_W       = 8;
    localparam int COUNT_W      = 12;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEVICE_ADDRESS = 2'd0,
        CFG_UNIT_CLOCKS    = 2'd1,
        CFG_PRE_CLOCKS     = 2'd2,
        CFG_POST_CLOCKS    = 2'd3
    } t_cfg_idx;

    // Register values after reset.
    localparam logic [DEV_W-1:0]  DEV_ADDR_RST = 7'h53;
    localparam logic [BYTE_W-1:0] UNIT_RST     = 8'd10;
    localparam logic [BYTE_W-1:0] PRE_RST      = 8'd60;
    localparam logic [BYTE_W-1:0] POST_RST     = 8'd60;

    // Request type codes.
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    // One input beat.
    typedef struct packed {
        logic              req_type;
        logic [BYTE_W-1:0] reg_addr;
        logic [BYTE_W-1:0] reg_value;
    } t_req;

    // One result beat.
    typedef struct packed {
        logic clock_pulse;
        logic select_level;
        logic busy_res;
        logic accepted;
        logic frame_done;
    } t_res;

endpackage

`default_nettype wire

// File: src/pwrwe_req_if.sv
// Request channel interface: valid/ready handshake with the request fields.
// Depends on pwrwe_pkg for field widths.
`default_nettype none

interface pwrwe_req_if;
    import pwrwe_pkg::*;

    logic              valid;
    logic              ready;
    logic              req_type;
    logic [BYTE_W-1:0] reg_addr;
    logic [BYTE_W-1:0] reg_value;

    modport source (output valid, output req_type, output reg_addr, output reg_value,
                    input ready);
    modport sink   (input valid, input req_type, input reg_addr, input reg_value,
                    output ready);
endinterface

`default_nettype wire

// File: src/pwrwe_res_if.sv
// Result channel interface: valid/ready handshake with the result fields.
// No package dependency; all fields are single bits.
`default_nettype none

interface pwrwe_res_if;
    logic valid;
    logic ready;
    logic clock_pulse;
    logic select_level;
    logic busy_res;
    logic accepted;
    logic frame_done;

    modport source (output valid, output clock_pulse, output select_level,
                    output busy_res, output accepted, output frame_done, input ready);
    modport sink   (input valid, input clock_pulse, input select_level,
                    input busy_res, input accepted, input frame_done, output ready);
endinterface

`default_nettype wire

// File: src/pwrwe_in_reg.sv
// Input register stage: captures one request beat and holds it until the
// engine consumes it. Depends on pwrwe_pkg.
`default_nettype none

module pwrwe_in_reg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire pwrwe_pkg::t_req i_data,
    input  wire logic          i_take,
    output logic               o_valid,
    output pwrwe_pkg::t_req    o_data
);
    import pwrwe_pkg::*;

    logic r_valid;
    t_req r_data;

    // Accept a new beat whenever the stage is empty or being drained.
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // Occupancy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload capture.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end
endmodule

`default_nettype wire

// File: src/pwrwe_engine.sv
// Frame engine: configuration registers, frame state and the per-beat step.
// Depends on pwrwe_pkg.
`default_nettype none

module pwrwe_engine #(
    parameter int FRAME_BITS = pwrwe_pkg::FRAME_BITS_D
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [pwrwe_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [pwrwe_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_fire,
    input  wire pwrwe_pkg::t_req                i_req,
    output pwrwe_pkg::t_res                     o_res
);
    import pwrwe_pkg::*;

    localparam int BIT_W = $clog2(FRAME_BITS);

    typedef enum logic [7:0] {
        PH_IDLE  = 8'b0000_0001,
        PH_PRE   = 8'b0000_0010,
        PH_START = 8'b0000_0100,
        PH_LEAD  = 8'b0000_1000,
        PH_MARK  = 8'b0001_0000,
        PH_GAP   = 8'b0010_0000,
        PH_STOP  = 8'b0100_0000,
        PH_POST  = 8'b1000_0000
    } t_phase;

    logic [DEV_W-1:0]   r_dev_addr;
    logic [BYTE_W-1:0]  r_unit;
    logic [BYTE_W-1:0]  r_pre;
    logic [BYTE_W-1:0]  r_post;

    t_phase             r_phase, n_phase;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [BIT_W-1:0]   r_bit_idx, n_bit_idx;
    logic [FRAME_W-1:0] r_frame, n_frame;
    logic               r_level, n_level;

    logic [BYTE_W-1:0]  w_unit;
    logic [5:0]         w_pos;
    logic               w_cur_bit;
    logic [COUNT_W-1:0] w_len;
    logic [COUNT_W-1:0] w_count_inc;
    logic [BIT_W:0]     w_bit_next;
    logic               w_phase_level;

    // A unit value of zero is treated as a value of one.
    assign w_unit = (r_unit == '0) ? BYTE_W'(1) : r_unit;

    // Bit being sent, MSB first; positions above the frame word send zero.
    assign w_pos     = 6'(FRAME_BITS - 1) - 6'(r_bit_idx);
    assign w_cur_bit = (w_pos < 6'(FRAME_W)) ? r_frame[w_pos[4:0]] : 1'b0;

    assign w_count_inc = r_count + COUNT_W'(1);
    assign w_bit_next  = (BIT_W+1)'(r_bit_idx) + (BIT_W+1)'(1);

    // Length of the current phase in clock periods.
    always_comb begin
        case (r_phase)
            PH_PRE:  w_len = COUNT_W'(r_pre);
            PH_MARK: w_len = w_cur_bit ? COUNT_W'(w_unit) * COUNT_W'(3) : COUNT_W'(w_unit);
            PH_STOP: w_len = COUNT_W'(w_unit) * COUNT_W'(13);
            PH_POST: w_len = COUNT_W'(r_post);
            PH_IDLE: w_len = '0;
            default: w_len = COUNT_W'(w_unit);
        endcase
    end

    // Select level driven during each phase.
    always_comb begin
        case (r_phase)
            PH_START, PH_MARK, PH_STOP, PH_POST: w_phase_level = 1'b1;
            default:                             w_phase_level = 1'b0;
        endcase
    end

    // Per-beat step: next state and the result beat.
    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_bit_idx = r_bit_idx;
        n_frame   = r_frame;
        n_level   = r_level;
        o_res     = '0;
        if (i_fire) begin
            if (i_req.req_type == REQ_WRITE) begin
                if (r_phase == PH_IDLE) begin
                    n_frame        = {r_dev_addr, 1'b0, i_req.reg_addr, i_req.reg_value};
                    n_bit_idx      = '0;
                    n_count        = '0;
                    n_phase        = (r_pre != '0) ? PH_PRE : PH_START;
                    o_res.accepted = 1'b1;
                end
            end else if (r_phase != PH_IDLE) begin
                o_res.clock_pulse = 1'b1;
                n_level           = w_phase_level;
                n_count           = w_count_inc;
                if (w_count_inc >= w_len) begin
                    n_count = '0;
                    case (r_phase)
                        PH_PRE:   n_phase = PH_START;
                        PH_START: n_phase = PH_LEAD;
                        PH_LEAD:  n_phase = PH_MARK;
                        PH_MARK:  n_phase = PH_GAP;
                        PH_GAP: begin
                            if (w_bit_next < (BIT_W+1)'(FRAME_BITS)) begin
                                n_bit_idx = w_bit_next[BIT_W-1:0];
                                n_phase   = PH_MARK;
                            end else begin
                                n_phase = PH_STOP;
                            end
                        end
                        PH_STOP:  n_phase = (r_post != '0) ? PH_POST : PH_IDLE;
                        default:  n_phase = PH_IDLE;
                    endcase
                    o_res.frame_done = (n_phase == PH_IDLE);
                end
            end
        end
        o_res.select_level = n_level;
        o_res.busy_res     = (n_phase != PH_IDLE);
    end

    // Frame state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_count   <= '0;
            r_bit_idx <= '0;
            r_frame   <= '0;
            r_level   <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_bit_idx <= n_bit_idx;
            r_frame   <= n_frame;
            r_level   <= n_level;
        end
    end

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= DEV_ADDR_RST;
            r_unit     <= UNIT_RST;
            r_pre      <= PRE_RST;
            r_post     <= POST_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_DEVICE_ADDRESS: r_dev_addr <= i_cfg_data[DEV_W-1:0];
                CFG_UNIT_CLOCKS:    r_unit     <= i_cfg_data;
                CFG_PRE_CLOCKS:     r_pre      <= i_cfg_data;
                CFG_POST_CLOCKS:    r_post     <= i_cfg_data;
                default:            r_unit     <= r_unit;
            endcase
        end
    end
endmodule

`default_nettype wire

// File: src/pwrwe_out_reg.sv
// Result register stage: holds one result beat until the receiver takes it.
// Depends on pwrwe_pkg.
`default_nettype none

module pwrwe_out_reg (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_load,
    input  wire pwrwe_pkg::t_res i_data,
    input  wire logic            i_ready,
    output logic                 o_space,
    output logic                 o_valid,
    output pwrwe_pkg::t_res      o_data
);
    import pwrwe_pkg::*;

    logic r_valid;
    t_res r_data;

    // Room for a new result when empty or when the current one leaves now.
    assign o_space = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // Occupancy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_load;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end
endmodule

`default_nettype wire

// File: src/pulse_width_register_write_encoder_unit.sv
// Top level of the select-line register write encoder.
// Depends on pwrwe_pkg, pwrwe_req_if, pwrwe_res_if and the pwrwe_* stages.
//
// Usage:
//   i_req carries request beats: req_type 0 starts a register write with
//   reg_addr and reg_value, req_type 1 is a tick that stands for a clock
//   period of the serial line. Every request beat yields exactly one result
//   beat on o_res, in order.
//   The configuration port (i_cfg_we, i_cfg_idx, i_cfg_data) writes device
//   address, unit length, pre and post lengths; write only while idle.
// Path and throughput:
//   A taken request is held in the input register, then the step logic
//   loads its result into the result register, which drives o_res. One
//   beat is taken per cycle while o_res is not held off.
// Reset:
//   Registers return to their defaults, the frame state goes idle and the
//   select level reads low; both stages come up empty.
// Stall:
//   While o_res is held off, the result and input registers fill, then
//   i_req.ready drops; nothing is lost or repeated.
`default_nettype none

module pulse_width_register_write_encoder_unit #(
    parameter int FRAME_BITS = pwrwe_pkg::FRAME_BITS_D
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [pwrwe_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [pwrwe_pkg::CFG_DATA_W-1:0] i_cfg_data,
    pwrwe_req_if.sink                             i_req,
    pwrwe_res_if.source                           o_res
);
    import pwrwe_pkg::*;

    t_req w_req_in;
    t_req w_req_held;
    t_res w_res_next;
    t_res w_res_out;
    logic w_held_valid;
    logic w_space;
    logic w_fire;

    assign w_req_in = '{req_type:  i_req.req_type,
                        reg_addr:  i_req.reg_addr,
                        reg_value: i_req.reg_value};

    // The engine steps whenever a request is held and the result stage has room.
    assign w_fire = w_held_valid && w_space;

    pwrwe_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (i_req.ready),
        .i_data  (w_req_in),
        .i_take  (w_fire),
        .o_valid (w_held_valid),
        .o_data  (w_req_held)
    );

    pwrwe_engine #(
        .FRAME_BITS (FRAME_BITS)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_fire     (w_fire),
        .i_req      (w_req_held),
        .o_res      (w_res_next)
    );

    pwrwe_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_fire),
        .i_data  (w_res_next),
        .i_ready (o_res.ready),
        .o_space (w_space),
        .o_valid (o_res.valid),
        .o_data  (w_res_out)
    );

    // Result fields onto the channel.
    assign o_res.clock_pulse  = w_res_out.clock_pulse;
    assign o_res.select_level = w_res_out.select_level;
    assign o_res.busy_res     = w_res_out.busy_res;
    assign o_res.accepted     = w_res_out.accepted;
    assign o_res.frame_done   = w_res_out.frame_done;

`ifndef SYNTHESIS
    // A finished frame is a clocked period that leaves the engine idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_res_next.frame_done) |-> (w_res_next.clock_pulse && !w_res_next.busy_res))
        else $error("frame_done without a clock period or with busy still set");

    // An accepted write drives no clock and always leaves a frame in progress.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_res_next.accepted) |-> (!w_res_next.clock_pulse && w_res_next.busy_res))
        else $error("accepted write with a clock period or without busy");

    // A held request that is not consumed stays held for the next cycle.
    a_hold_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_held_valid && !w_fire) |=> w_held_valid)
        else $error("held request lost without being consumed");
`endif

endmodule

`default_nettype wire
